// ===== sv/tmfb_pkg.sv =====
package tmfb_pkg;

    localparam int C_NSLOT     = 6;
    localparam int C_CNT_W     = 5;
    localparam int C_X_W       = 22;
    localparam int C_Q_W       = 18;
    localparam int C_RECIP_SH  = 22;

    typedef logic signed [9:0]  t_mix;
    typedef logic signed [24:0] t_num;
    typedef logic [C_X_W-1:0]   t_x;
    typedef logic [C_Q_W-1:0]   t_q;
    typedef logic [15:0]        t_duty;
    typedef logic [C_CNT_W-1:0] t_cnt;

    localparam logic [7:0] C_HDR0 = 8'hA7;
    localparam logic [7:0] C_HDR1 = 8'h18;
    localparam logic [7:0] C_HDR2 = 8'h0F;
    localparam logic [7:0] C_HDR3 = 8'h0C;
    localparam logic [7:0] C_FTR  = 8'h7A;

    localparam t_cnt C_IDX_HDR0 = 5'd0;
    localparam t_cnt C_IDX_HDR1 = 5'd1;
    localparam t_cnt C_IDX_HDR2 = 5'd2;
    localparam t_cnt C_IDX_HDR3 = 5'd3;
    localparam t_cnt C_IDX_DATA = 5'd4;
    localparam t_cnt C_IDX_LAST = 5'd16;

    localparam t_num  C_SPAN      = 25'sd32767;
    localparam t_num  C_BASE_H    = 25'sd2949120;   // 49152 * 60
    localparam t_num  C_BASE_V    = 25'sd1966080;   // 49152 * 40
    localparam t_num  C_LOW_H     = 25'sd1966080;   // 32768 * 60
    localparam t_num  C_LOW_V     = 25'sd1310720;   // 32768 * 40
    localparam t_duty C_DUTY_MIN  = 16'h8000;
    localparam t_duty C_DUTY_MAX  = 16'hFFFF;

    // after the power-of-two part: horizontal /15, vertical /5
    localparam logic [3:0]      C_ODD_H   = 4'd15;
    localparam logic [3:0]      C_ODD_V   = 4'd5;
    localparam logic [C_X_W-1:0] C_RECIP_H = 22'd279620;
    localparam logic [C_X_W-1:0] C_RECIP_V = 22'd838860;

    // vertical thruster slots are 0 and 3
    localparam logic [C_NSLOT-1:0] C_VERT = 6'b001001;

endpackage

// ===== sv/thruster_mix_frame_builder.sv =====
// Thruster mix frame builder. Each request on the slave side carries one motion
// command (surge, sway, heave, yaw, roll as signed bytes); the block mixes it into
// six thruster duty values in 32768..65535 (saturating at both ends) and sends a
// 17-byte frame on the master side: A7 18 0F 0C, slots 0..5 low byte first, then 7A,
// with tlast on the footer. The mixing and scaling take three register stages and a
// command is held in the frame serialiser while the next ones move up behind it, so
// a command can be taken every cycle until the stages are full; sustained, the
// serialiser sets the pace, one frame byte per cycle while i_m_tready is high.
module thruster_mix_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // surge, sway, heave, yaw_rate, roll_rate
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // frame_byte
    output logic        o_m_tlast
);
    import tmfb_pkg::*;

    logic  r_s1_v, r_s2_v, r_s3_v, r_busy;
    t_mix  r_s1_m  [C_NSLOT];
    t_x    r_s2_x  [C_NSLOT];
    logic  [C_NSLOT-1:0] r_s2_lo, r_s3_lo;
    t_x    r_s3_x  [C_NSLOT];
    t_q    r_s3_q0 [C_NSLOT];
    t_duty r_duty  [C_NSLOT];
    t_cnt  r_cnt;

    t_mix  n_m     [C_NSLOT];
    t_x    n_x     [C_NSLOT];
    logic  [C_NSLOT-1:0] n_lo;
    t_q    n_q0    [C_NSLOT];
    t_duty n_duty  [C_NSLOT];

    logic adv1, adv2, adv3, ser_load, out_xfer, out_end;
    t_mix f, s, u, y, r;

    assign out_xfer = r_busy && i_m_tready;
    assign out_end  = out_xfer && (r_cnt == C_IDX_LAST);
    assign ser_load = r_s3_v && (!r_busy || out_end);
    assign adv3     = !r_s3_v || ser_load;
    assign adv2     = !r_s2_v || adv3;
    assign adv1     = !r_s1_v || adv2;
    assign o_s_tready = adv1;

    // stage 1: mixing sums
    always_comb begin
        f = 10'(signed'(i_s_tdata[7:0]));
        s = 10'(signed'(i_s_tdata[15:8]));
        u = 10'(signed'(i_s_tdata[23:16]));
        y = 10'(signed'(i_s_tdata[31:24]));
        r = 10'(signed'(i_s_tdata[39:32]));
        n_m[0] = u - r;
        n_m[1] = f + s + y;
        n_m[2] = f - s + y;
        n_m[3] = u + r;
        n_m[4] = f + s - y;
        n_m[5] = f - s - y;
    end

    // stage 2: scaled numerator, low clamp and power-of-two part of the divide
    always_comb begin
        for (int i = 0; i < C_NSLOT; i++) begin
            t_num num;
            num = 25'(r_s1_m[i]) * C_SPAN + (C_VERT[i] ? C_BASE_V : C_BASE_H);
            n_lo[i] = num < (C_VERT[i] ? C_LOW_V : C_LOW_H);
            n_x[i]  = C_VERT[i] ? C_X_W'(num[23:3]) : num[23:2];
        end
    end

    // stage 3: reciprocal multiply, quotient may come out one short
    always_comb begin
        for (int i = 0; i < C_NSLOT; i++) begin
            logic [2*C_X_W-1:0] prod;
            prod = (2*C_X_W)'(r_s2_x[i]) * (2*C_X_W)'(C_VERT[i] ? C_RECIP_V : C_RECIP_H);
            n_q0[i] = prod[C_RECIP_SH+C_Q_W-1:C_RECIP_SH];
        end
    end

    // correction and saturation into the serialiser
    always_comb begin
        for (int i = 0; i < C_NSLOT; i++) begin
            logic [3:0]     d;
            t_x             rem;
            logic [C_Q_W:0] q;
            d   = C_VERT[i] ? C_ODD_V : C_ODD_H;
            rem = r_s3_x[i] - C_X_W'(r_s3_q0[i]) * C_X_W'(d);
            q   = (C_Q_W+1)'(r_s3_q0[i]) + ((rem >= C_X_W'(d)) ? 1'b1 : 1'b0);
            if (r_s3_lo[i]) begin
                n_duty[i] = C_DUTY_MIN;
            end else if (q > (C_Q_W+1)'(C_DUTY_MAX)) begin
                n_duty[i] = C_DUTY_MAX;
            end else begin
                n_duty[i] = q[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (adv1) begin
                r_s1_v <= i_s_tvalid;
            end
            if (adv2) begin
                r_s2_v <= r_s1_v;
            end
            if (adv3) begin
                r_s3_v <= r_s2_v;
            end
            if (ser_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (out_end) begin
                r_busy <= 1'b0;
            end else if (out_xfer) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_s_tvalid) begin
            r_s1_m <= n_m;
        end
        if (adv2 && r_s1_v) begin
            r_s2_x  <= n_x;
            r_s2_lo <= n_lo;
        end
        if (adv3 && r_s2_v) begin
            r_s3_x  <= r_s2_x;
            r_s3_q0 <= n_q0;
            r_s3_lo <= r_s2_lo;
        end
        if (ser_load) begin
            r_duty <= n_duty;
        end
    end

    // frame byte select
    always_comb begin
        t_cnt  idx;
        t_duty sel;
        idx = r_cnt - C_IDX_DATA;
        sel = r_duty[idx[3:1]];
        unique case (r_cnt)
            C_IDX_HDR0: o_m_tdata = C_HDR0;
            C_IDX_HDR1: o_m_tdata = C_HDR1;
            C_IDX_HDR2: o_m_tdata = C_HDR2;
            C_IDX_HDR3: o_m_tdata = C_HDR3;
            C_IDX_LAST: o_m_tdata = C_FTR;
            default:    o_m_tdata = idx[0] ? sel[15:8] : sel[7:0];
        endcase
    end

    assign o_m_tvalid = r_busy;
    assign o_m_tlast  = r_busy && (r_cnt == C_IDX_LAST);

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= C_IDX_LAST))
        else $error("frame counter out of range");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !out_end) |=> (r_busy && r_cnt == $past(r_cnt) + 1'b1))
        else $error("frame counter did not advance");

    a_duty_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_cnt[0] && r_cnt >= 5'd5 && r_cnt <= 5'd15) |-> o_m_tdata[7])
        else $error("duty high byte below saturation floor");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_v |-> o_s_tready)
        else $error("empty pipeline refused a request");

endmodule
